// ===== hdl/i2cm_pkg.sv =====
`default_nettype none

package i2cm_pkg;

    localparam int BITS_PER_BYTE   = 8;
    localparam int BIT_IDX_W       = $clog2(BITS_PER_BYTE);
    localparam int PHASE_W         = 5;
    localparam int TICK_W          = 16;
    localparam int SUB_W           = 2;

    localparam logic [TICK_W-1:0]  PHASE_TICKS_RESET = 16'd10;
    localparam logic [SUB_W-1:0]   SUB_SDA   = 2'd0;
    localparam logic [SUB_W-1:0]   SUB_LAST  = 2'd2;

    typedef enum logic [2:0] {
        CMD_START     = 3'd0,
        CMD_STOP      = 3'd1,
        CMD_SEND_BYTE = 3'd2,
        CMD_RECV_BYTE = 3'd3,
        CMD_SEND_ACK  = 3'd4,
        CMD_RECV_ACK  = 3'd5
    } cmd_t;

    typedef enum logic [1:0] {
        ACT_SCL  = 2'd0,
        ACT_SDA  = 2'd1,
        ACT_READ = 2'd2
    } act_t;

    typedef struct packed {
        act_t                 act;
        logic                 val;
        logic [BIT_IDX_W-1:0] rx_pos;
    } phase_act_t;

    function automatic logic [PHASE_W-1:0] phase_last(input cmd_t cmd);
        logic [PHASE_W-1:0] n;
        begin
            unique case (cmd)
                CMD_START:     n = PHASE_W'(3);
                CMD_STOP:      n = PHASE_W'(2);
                CMD_SEND_BYTE: n = PHASE_W'(3 * BITS_PER_BYTE - 1);
                CMD_RECV_BYTE: n = PHASE_W'(3 * BITS_PER_BYTE);
                CMD_SEND_ACK:  n = PHASE_W'(2);
                CMD_RECV_ACK:  n = PHASE_W'(3);
                default:       n = PHASE_W'(3);
            endcase
            return n;
        end
    endfunction

endpackage

`default_nettype wire

// ===== hdl/i2cm_phase_dec.sv =====
`default_nettype none

module i2cm_phase_dec
    import i2cm_pkg::*;
(
    input  wire cmd_t                  cmd,
    input  wire logic [PHASE_W-1:0]    phase,
    input  wire logic [SUB_W-1:0]      sub,
    input  wire logic [BIT_IDX_W-1:0]  bit_idx,
    input  wire logic [BITS_PER_BYTE-1:0] tx_shift,
    output phase_act_t                 pa
);

    logic [BIT_IDX_W-1:0] msb_pos;

    always_comb
    begin
        msb_pos   = BIT_IDX_W'(BITS_PER_BYTE - 1) - bit_idx;
        pa.act    = ACT_SCL;
        pa.val    = 1'b0;
        pa.rx_pos = msb_pos;
        unique case (cmd)
            CMD_START:
            begin
                pa.act = phase[0] ? ACT_SCL : ACT_SDA;
                pa.val = ~phase[1];
            end
            CMD_STOP:
            begin
                if (phase == PHASE_W'(0))
                begin
                    pa.act = ACT_SDA;
                    pa.val = 1'b0;
                end
                else if (phase == PHASE_W'(1))
                begin
                    pa.act = ACT_SCL;
                    pa.val = 1'b1;
                end
                else
                begin
                    pa.act = ACT_SDA;
                    pa.val = 1'b1;
                end
            end
            CMD_SEND_BYTE:
            begin
                if (sub == SUB_SDA)
                begin
                    pa.act = ACT_SDA;
                    pa.val = tx_shift[msb_pos];
                end
                else
                begin
                    pa.act = ACT_SCL;
                    pa.val = (sub != SUB_LAST);
                end
            end
            CMD_RECV_BYTE:
            begin
                if (phase == PHASE_W'(0))
                begin
                    pa.act = ACT_SDA;
                    pa.val = 1'b1;
                end
                else if (sub == SUB_W'(1))
                begin
                    pa.act = ACT_READ;
                end
                else
                begin
                    pa.act = ACT_SCL;
                    pa.val = (sub == SUB_SDA);
                end
            end
            CMD_SEND_ACK:
            begin
                if (phase == PHASE_W'(0))
                begin
                    pa.act = ACT_SDA;
                    pa.val = tx_shift[0];
                end
                else
                begin
                    pa.act = ACT_SCL;
                    pa.val = (phase == PHASE_W'(1));
                end
            end
            default:
            begin
                unique case (phase[1:0])
                    2'd0:
                    begin
                        pa.act = ACT_SDA;
                        pa.val = 1'b1;
                    end
                    2'd1:
                    begin
                        pa.act = ACT_SCL;
                        pa.val = 1'b1;
                    end
                    2'd2:
                    begin
                        pa.act = ACT_READ;
                    end
                    default:
                    begin
                        pa.act = ACT_SCL;
                        pa.val = 1'b0;
                    end
                endcase
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== hdl/i2c_master_bit_sequencer.sv =====
// I2C master bit sequencer: each accepted input word is one timing tick and
// yields one result word, so a word can be taken every clock cycle unless
// out_ready stalls a full result register, the only stage, which refills in
// the cycle it is taken. Commands (start, stop, send byte, receive byte,
// send ack, receive ack) are taken only while idle; each runs a fixed list
// of line phases, and every phase lasts phase_ticks words (zero counts as
// one). scl_out and sda_out are open-drain drives, 1 meaning released.
// Write phase_ticks only while no command is running.
`default_nettype none

module i2c_master_bit_sequencer
    import i2cm_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,

    input  wire logic                     cfg_valid,
    output logic                          cfg_ready,
    input  wire logic [TICK_W-1:0]        cfg_data,

    input  wire logic                     in_valid,
    output logic                          in_ready,
    input  wire logic                     cmd_valid,
    input  wire logic [2:0]               mode,
    input  wire logic [BITS_PER_BYTE-1:0] tx_byte,
    input  wire logic                     ack_to_send,
    input  wire logic                     sda_in,

    output logic                          out_valid,
    input  wire logic                     out_ready,
    output logic                          scl_out,
    output logic                          sda_out,
    output logic                          busy_res,
    output logic                          done_res,
    output logic [BITS_PER_BYTE-1:0]      rx_byte,
    output logic                          ack_received
);

    logic [TICK_W-1:0]        phase_ticks_reg;
    logic                     run_reg, run_next;
    cmd_t                     cmd_reg, cmd_next;
    logic [PHASE_W-1:0]       phase_reg, phase_next;
    logic [TICK_W-1:0]        tick_reg, tick_next;
    logic [SUB_W-1:0]         sub_reg, sub_next;
    logic [BIT_IDX_W-1:0]     bit_reg, bit_next;
    logic [BITS_PER_BYTE-1:0] tx_reg, tx_next;
    logic [BITS_PER_BYTE-1:0] rx_reg, rx_next;
    logic                     scl_reg, scl_next;
    logic                     sda_reg, sda_next;
    logic                     ack_reg, ack_next;
    logic                     done_next;
    logic                     out_valid_reg;
    logic                     busy_out_reg, done_out_reg;

    logic                     in_fire;
    logic                     start;
    logic                     run_c;
    cmd_t                     cmd_c;
    logic [PHASE_W-1:0]       phase_c;
    logic [TICK_W-1:0]        tick_c;
    logic [SUB_W-1:0]         sub_c;
    logic [BIT_IDX_W-1:0]     bit_c;
    logic [BITS_PER_BYTE-1:0] tx_c;
    logic [BITS_PER_BYTE-1:0] rx_c;
    logic [TICK_W-1:0]        len;
    logic [TICK_W:0]          tick_inc;
    logic                     phase_end;
    phase_act_t               pa;

    assign cfg_ready = 1'b1;
    assign in_ready  = ~out_valid_reg | out_ready;
    assign in_fire   = in_valid & in_ready;

    assign out_valid    = out_valid_reg;
    assign scl_out      = scl_reg;
    assign sda_out      = sda_reg;
    assign busy_res     = busy_out_reg;
    assign done_res     = done_out_reg;
    assign rx_byte      = rx_reg;
    assign ack_received = ack_reg;

    // take a new command only while idle
    always_comb
    begin
        start   = ~run_reg & cmd_valid & (mode <= 3'(CMD_RECV_ACK));
        run_c   = run_reg | start;
        cmd_c   = start ? cmd_t'(mode) : cmd_reg;
        phase_c = start ? '0 : phase_reg;
        tick_c  = start ? '0 : tick_reg;
        sub_c   = start ? '0 : sub_reg;
        bit_c   = start ? '0 : bit_reg;
        tx_c    = tx_reg;
        rx_c    = rx_reg;
        if (start && cmd_t'(mode) == CMD_SEND_BYTE)
            tx_c = tx_byte;
        else if (start && cmd_t'(mode) == CMD_SEND_ACK)
            tx_c = {{(BITS_PER_BYTE-1){1'b0}}, ack_to_send};
        if (start && cmd_t'(mode) == CMD_RECV_BYTE)
            rx_c = '0;
    end

    i2cm_phase_dec u_dec (
        .cmd      (cmd_c),
        .phase    (phase_c),
        .sub      (sub_c),
        .bit_idx  (bit_c),
        .tx_shift (tx_c),
        .pa       (pa)
    );

    always_comb
    begin
        len       = (phase_ticks_reg == '0) ? TICK_W'(1) : phase_ticks_reg;
        tick_inc  = {1'b0, tick_c} + (TICK_W+1)'(1);
        phase_end = (tick_inc >= {1'b0, len});

        run_next   = run_c;
        cmd_next   = cmd_c;
        phase_next = phase_c;
        tick_next  = tick_c;
        sub_next   = sub_c;
        bit_next   = bit_c;
        tx_next    = tx_c;
        rx_next    = rx_c;
        scl_next   = scl_reg;
        sda_next   = sda_reg;
        ack_next   = ack_reg;
        done_next  = 1'b0;

        if (run_c)
        begin
            // act on the first tick of a phase
            if (tick_c == '0)
            begin
                unique case (pa.act)
                    ACT_SCL:  scl_next = pa.val;
                    ACT_SDA:  sda_next = pa.val;
                    default:
                    begin
                        if (cmd_c == CMD_RECV_BYTE)
                            rx_next[pa.rx_pos] = rx_c[pa.rx_pos] | sda_in;
                        else
                            ack_next = sda_in;
                    end
                endcase
            end

            tick_next = tick_inc[TICK_W-1:0];
            if (phase_end)
            begin
                tick_next = '0;
                // advance the bit-cell position, skipping the receive preamble
                if (!(cmd_c == CMD_RECV_BYTE && phase_c == '0))
                begin
                    if (sub_c == SUB_LAST)
                    begin
                        sub_next = '0;
                        bit_next = bit_c + BIT_IDX_W'(1);
                    end
                    else
                    begin
                        sub_next = sub_c + SUB_W'(1);
                    end
                end
                if (phase_c == phase_last(cmd_c))
                begin
                    phase_next = '0;
                    run_next   = 1'b0;
                    done_next  = 1'b1;
                end
                else
                begin
                    phase_next = phase_c + PHASE_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_ticks_reg <= PHASE_TICKS_RESET;
            run_reg         <= 1'b0;
            cmd_reg         <= CMD_START;
            phase_reg       <= '0;
            tick_reg        <= '0;
            sub_reg         <= '0;
            bit_reg         <= '0;
            tx_reg          <= '0;
            rx_reg          <= '0;
            scl_reg         <= 1'b1;
            sda_reg         <= 1'b1;
            ack_reg         <= 1'b0;
            out_valid_reg   <= 1'b0;
            busy_out_reg    <= 1'b0;
            done_out_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                phase_ticks_reg <= cfg_data;
            if (in_fire)
            begin
                run_reg       <= run_next;
                cmd_reg       <= cmd_next;
                phase_reg     <= phase_next;
                tick_reg      <= tick_next;
                sub_reg       <= sub_next;
                bit_reg       <= bit_next;
                tx_reg        <= tx_next;
                rx_reg        <= rx_next;
                scl_reg       <= scl_next;
                sda_reg       <= sda_next;
                ack_reg       <= ack_next;
                busy_out_reg  <= run_c;
                done_out_reg  <= done_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

// ===== test/tb.sv =====
`default_nettype none

module tb;
    import i2cm_pkg::*;

    localparam int STALL_CYCLES   = 300;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int MAX_REPORTS    = 10;
    localparam int RANDOM_ROUNDS  = 6;
    localparam int ROUND_TICKS    = 250;

    localparam logic [2:0]        MODE_RSVD_6 = 3'd6;
    localparam logic [2:0]        MODE_RSVD_7 = 3'd7;
    localparam logic [TICK_W-1:0] LEN_ZERO    = 16'd0;
    localparam logic [TICK_W-1:0] LEN_ONE     = 16'd1;
    localparam logic [TICK_W-1:0] LEN_LONG    = 16'd100;

    typedef struct packed {
        logic                     scl;
        logic                     sda;
        logic                     busy;
        logic                     done;
        logic [BITS_PER_BYTE-1:0] rx;
        logic                     ack;
    } bus_word_t;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     cfg_valid = 1'b0;
    logic                     cfg_ready;
    logic [TICK_W-1:0]        cfg_data = '0;
    logic                     in_valid = 1'b0;
    logic                     in_ready;
    logic                     cmd_valid = 1'b0;
    logic [2:0]               mode = '0;
    logic [BITS_PER_BYTE-1:0] tx_byte = '0;
    logic                     ack_to_send = 1'b0;
    logic                     sda_in = 1'b0;
    logic                     out_valid;
    logic                     out_ready = 1'b0;
    logic                     scl_out;
    logic                     sda_out;
    logic                     busy_res;
    logic                     done_res;
    logic [BITS_PER_BYTE-1:0] rx_byte;
    logic                     ack_received;

    // bus sequencer mirror
    logic [TICK_W-1:0]        phase_len = PHASE_TICKS_RESET;
    logic                     line_scl = 1'b1;
    logic                     line_sda = 1'b1;
    logic                     seq_running = 1'b0;
    logic                     ack_bit = 1'b0;
    cmd_t                     seq_cmd = CMD_START;
    int                       phase_no = 0;
    int                       tick_no = 0;
    logic [BITS_PER_BYTE-1:0] tx_hold = '0;
    logic [BITS_PER_BYTE-1:0] rx_hold = '0;

    bus_word_t bus_expect_q[$];
    bus_word_t want;
    bus_word_t got;

    int  errors = 0;
    int  ticks_sent = 0;
    int  cmds_started = 0;
    int  len_writes = 0;
    int  send_gap_max = 15;
    int  recv_gap_max = 15;
    int  rx_wait = 0;
    int  hold_left = 0;
    int  idle_cycles = 0;
    bit  stall_req = 1'b0;

    i2c_master_bit_sequencer dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .cmd_valid    (cmd_valid),
        .mode         (mode),
        .tx_byte      (tx_byte),
        .ack_to_send  (ack_to_send),
        .sda_in       (sda_in),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .scl_out      (scl_out),
        .sda_out      (sda_out),
        .busy_res     (busy_res),
        .done_res     (done_res),
        .rx_byte      (rx_byte),
        .ack_received (ack_received)
    );

    always #4 clk = ~clk;

    function automatic int phases_of(cmd_t c);
        case (c)
            CMD_START:     return 4;
            CMD_STOP:      return 3;
            CMD_SEND_BYTE: return 3 * BITS_PER_BYTE;
            CMD_RECV_BYTE: return 3 * BITS_PER_BYTE + 1;
            CMD_SEND_ACK:  return 3;
            default:       return 4;
        endcase
    endfunction

    function automatic bus_word_t advance_bus(logic cv, logic [2:0] md,
                                              logic [BITS_PER_BYTE-1:0] tx,
                                              logic ack, logic sda);
        bus_word_t r;
        int        len;
        int        sub;
        int        bitpos;
        int        p;
        len = (phase_len == LEN_ZERO) ? 1 : int'(phase_len);
        r = '0;
        if (!seq_running && cv && md <= CMD_RECV_ACK)
        begin
            seq_running = 1'b1;
            seq_cmd = cmd_t'(md);
            phase_no = 0;
            tick_no = 0;
            if (md == CMD_SEND_BYTE)
                tx_hold = tx;
            else if (md == CMD_SEND_ACK)
                tx_hold = {{(BITS_PER_BYTE-1){1'b0}}, ack};
            if (md == CMD_RECV_BYTE)
                rx_hold = '0;
            cmds_started++;
        end
        if (seq_running)
        begin
            r.busy = 1'b1;
            if (tick_no == 0)
            begin
                p = phase_no;
                case (seq_cmd)
                    CMD_START:
                        case (p % 4)
                            0:       line_sda = 1'b1;
                            1:       line_scl = 1'b1;
                            2:       line_sda = 1'b0;
                            default: line_scl = 1'b0;
                        endcase
                    CMD_STOP:
                        if (p == 0)
                            line_sda = 1'b0;
                        else if (p == 1)
                            line_scl = 1'b1;
                        else
                            line_sda = 1'b1;
                    CMD_SEND_BYTE:
                    begin
                        sub = p % 3;
                        bitpos = (p / 3) % BITS_PER_BYTE;
                        if (sub == 0)
                            line_sda = tx_hold[BITS_PER_BYTE-1-bitpos];
                        else
                            line_scl = (sub == 1);
                    end
                    CMD_RECV_BYTE:
                        if (p == 0)
                            line_sda = 1'b1;
                        else
                        begin
                            sub = (p - 1) % 3;
                            bitpos = ((p - 1) / 3) % BITS_PER_BYTE;
                            if (sub == 1)
                            begin
                                if (sda)
                                    rx_hold[BITS_PER_BYTE-1-bitpos] = 1'b1;
                            end
                            else
                                line_scl = (sub == 0);
                        end
                    CMD_SEND_ACK:
                        if (p == 0)
                            line_sda = tx_hold[0];
                        else
                            line_scl = (p == 1);
                    default:
                        case (p % 4)
                            0:       line_sda = 1'b1;
                            1:       line_scl = 1'b1;
                            2:       ack_bit = sda;
                            default: line_scl = 1'b0;
                        endcase
                endcase
            end
            tick_no++;
            if (tick_no >= len)
            begin
                tick_no = 0;
                phase_no++;
                if (phase_no >= phases_of(seq_cmd))
                begin
                    phase_no = 0;
                    seq_running = 1'b0;
                    r.done = 1'b1;
                end
            end
        end
        r.scl = line_scl;
        r.sda = line_sda;
        r.rx = rx_hold;
        r.ack = ack_bit;
        return r;
    endfunction

    task automatic send_tick(input logic cv, input logic [2:0] md,
                             input logic [BITS_PER_BYTE-1:0] tx,
                             input logic ack, input logic sda);
        int gap;
        gap = $urandom_range(send_gap_max, 0);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        cmd_valid <= cv;
        mode <= md;
        tx_byte <= tx;
        ack_to_send <= ack;
        sda_in <= sda;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        bus_expect_q.push_back(advance_bus(cv, md, tx, ack, sda));
        ticks_sent++;
    endtask

    task automatic send_idle_tick();
        send_tick(1'b0, 3'($urandom_range(7, 0)), 8'($urandom), 1'($urandom),
                  1'($urandom));
    endtask

    task automatic run_command(input logic [2:0] md, input logic [BITS_PER_BYTE-1:0] tx,
                               input logic ack, input logic sda);
        send_tick(1'b1, md, tx, ack, sda);
        while (seq_running)
            send_tick(1'b0, md, tx, ack, sda);
    endtask

    task automatic drain_bus();
        while (seq_running)
            send_idle_tick();
        in_valid <= 1'b0;
        while (bus_expect_q.size() != 0)
            @(posedge clk);
        @(posedge clk);
    endtask

    task automatic write_phase_len(input logic [TICK_W-1:0] v);
        drain_bus();
        cfg_valid <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        phase_len = v;
        len_writes++;
    endtask

    task automatic test_reset_timing();
        run_command(CMD_START, 8'h00, 1'b0, 1'b1);
        run_command(CMD_STOP, 8'h00, 1'b0, 1'b1);
    endtask

    task automatic test_each_command();
        write_phase_len(LEN_ONE);
        run_command(CMD_START, 8'h00, 1'b0, 1'b0);
        run_command(CMD_SEND_BYTE, 8'h00, 1'b0, 1'b0);
        run_command(CMD_SEND_BYTE, 8'hFF, 1'b1, 1'b1);
        run_command(CMD_SEND_BYTE, 8'hA5, 1'b0, 1'b1);
        run_command(CMD_RECV_BYTE, 8'h00, 1'b0, 1'b1);
        run_command(CMD_RECV_BYTE, 8'hFF, 1'b1, 1'b0);
        run_command(CMD_SEND_ACK, 8'h00, 1'b0, 1'b1);
        run_command(CMD_SEND_ACK, 8'hFF, 1'b1, 1'b0);
        run_command(CMD_RECV_ACK, 8'h00, 1'b0, 1'b0);
        run_command(CMD_RECV_ACK, 8'h00, 1'b0, 1'b1);
        run_command(CMD_STOP, 8'h00, 1'b0, 1'b0);
    endtask

    task automatic test_ignored_commands();
        write_phase_len(16'd2);
        send_tick(1'b1, CMD_RECV_BYTE, 8'h3C, 1'b1, 1'b1);
        while (seq_running)
            send_tick(1'b1, 3'($urandom_range(7, 0)), 8'($urandom), 1'($urandom),
                      1'($urandom));
        send_tick(1'b1, MODE_RSVD_6, 8'hFF, 1'b1, 1'b1);
        send_tick(1'b1, MODE_RSVD_7, 8'hFF, 1'b1, 1'b0);
        send_idle_tick();
    endtask

    task automatic test_zero_length();
        write_phase_len(LEN_ZERO);
        run_command(CMD_SEND_BYTE, 8'h5A, 1'b0, 1'b0);
        run_command(CMD_RECV_ACK, 8'h00, 1'b0, 1'b1);
    endtask

    task automatic test_long_phase();
        send_gap_max = 0;
        recv_gap_max = 0;
        write_phase_len(LEN_LONG);
        run_command(CMD_STOP, 8'h00, 1'b0, 1'b1);
        send_gap_max = 15;
        recv_gap_max = 15;
    endtask

    task automatic test_backpressure();
        int k;
        write_phase_len(LEN_ONE);
        send_gap_max = 0;
        stall_req = 1'b1;
        send_tick(1'b1, CMD_RECV_BYTE, 8'h00, 1'b0, 1'b1);
        for (k = 0; k < 60; k++)
            send_idle_tick();
        send_gap_max = 15;
    endtask

    task automatic test_random_traffic();
        int round;
        int n;
        for (round = 0; round < RANDOM_ROUNDS; round++)
        begin
            send_gap_max = (round % 2 == 1) ? 0 : 15;
            recv_gap_max = (round % 3 == 1) ? 0 : 15;
            write_phase_len((round == 0) ? LEN_ONE : 16'($urandom_range(4, 1)));
            for (n = 0; n < ROUND_TICKS; n++)
            begin
                if (!seq_running && $urandom_range(9, 0) != 0)
                    send_tick(1'b1,
                              ($urandom_range(19, 0) == 0) ? 3'($urandom_range(7, 6))
                                                           : 3'($urandom_range(5, 0)),
                              8'($urandom), 1'($urandom), 1'($urandom));
                else if ($urandom_range(19, 0) == 0)
                    send_tick(1'b1, 3'($urandom_range(7, 0)), 8'($urandom), 1'($urandom),
                              1'($urandom));
                else
                    send_idle_tick();
            end
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            got = {scl_out, sda_out, busy_res, done_res, rx_byte, ack_received};
            if (bus_expect_q.size() == 0)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("unexpected result word at %0t", $time);
            end
            else
            begin
                want = bus_expect_q.pop_front();
                if (got.scl !== want.scl || got.sda !== want.sda || got.busy !== want.busy
                    || got.done !== want.done || got.rx !== want.rx || got.ack !== want.ack)
                begin
                    errors++;
                    if (errors <= MAX_REPORTS)
                        $display({"mismatch at %0t: expected scl=%b sda=%b busy=%b ",
                                  "done=%b rx=%h ack=%b, got scl=%b sda=%b busy=%b ",
                                  "done=%b rx=%h ack=%b"},
                                 $time, want.scl, want.sda, want.busy, want.done, want.rx,
                                 want.ack, got.scl, got.sda, got.busy, got.done, got.rx,
                                 got.ack);
                end
            end
            rx_wait = $urandom_range(recv_gap_max, 0);
        end
        if (stall_req)
        begin
            hold_left = STALL_CYCLES;
            stall_req = 1'b0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else if (rx_wait > 0)
        begin
            rx_wait--;
            out_ready <= 1'b0;
        end
        else
            out_ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            idle_cycles = 0;
        else
        begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("FAILED: results differ");
                $finish;
            end
        end
    end

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_timing();
        test_each_command();
        test_ignored_commands();
        test_zero_length();
        test_long_phase();
        test_backpressure();
        test_random_traffic();
        drain_bus();
        repeat (10) @(posedge clk);
        errors += bus_expect_q.size();
        $display("covered %0d ticks and %0d commands over %0d phase-length writes",
                 ticks_sent, cmds_started, len_writes);
        $display({"phase lengths 0, 1, small random, reset value and 100; ",
                  "busy and reserved commands; output stall"});
        if (errors == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

`default_nettype wire

// ===== i2c_master_bit_sequencer.f =====
hdl/i2cm_pkg.sv
hdl/i2cm_phase_dec.sv
hdl/i2c_master_bit_sequencer.sv
test/tb.sv
